@@ hdl/rau_pkg.sv @@
// package for the rational arithmetic unit: payload types, opcodes, commands
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WordBitsDefault = 32;

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_CMP  = 3'd5;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               den_zero_error;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic prod;      // register cross products
    logic form;      // form n, d and flags
    logic gcd_init;  // start gcd remainder chain
    logic div_step;  // one restoring division bit
    logic div_init;  // start a new division
    logic div_next;  // pick next division (gcd step or quotient)
    logic emit;      // move result into output register
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_gcd;   // result to reduce, n and d both positive
    logic div_done;   // last bit of current division
    logic gcd_done;   // remainder reached zero
    logic quot_done;  // both quotients finished
  } rau_sts_t;

endpackage

@@ hdl/rational_arithmetic_unit.sv @@
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
//  channel | signals                      | transfer when
//  in      | in_valid, in_ready, in_item   | in_valid && in_ready
//  out     | out_valid, out_ready, out_item| out_valid && out_ready
//
// one item at a time: load, product, form and fix; reduction runs a bit-serial
// restoring divider, each division with setup and close-out, once for each
// remainder step of the gcd and then twice more for the quotients; when no
// reduction applies, fix goes straight to emit
// synchronous active-high reset returns to idle with no result pending
// a stalled output holds its result; the next item is taken once it drains
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  // controller sequences the datapath, one command set per cycle
  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .in_item, .cmd, .sts, .out_item
  );

endmodule

@@ hdl/rau_datapath.sv @@
// datapath: operand registers, cross products, shared bit-serial divider
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic      clk,
  input  in_item_t  in_item,
  input  rau_cmd_t  cmd,
  output rau_sts_t  sts,
  output out_item_t out_item
);

  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic [2:0]   op;
  logic [W-1:0] an, ad, bn, bd;
  logic [W-1:0] p_anbd, p_adbn, p_anbn, p_adbd;
  logic [W-1:0] n, d;
  logic         err, gt, lt, eq, make;

  // values formed from the cross products
  logic [W-1:0] n_form, d_form, diff_gt, diff_lt;
  logic         make_form, gt_form, lt_form, eq_form, err_form;

  // divider state
  logic [W-1:0] dvd, dvs, rem, quo;
  logic [CW-1:0] cnt;
  logic [1:0]   phase;  // 0 gcd, 1 n/g, 2 d/g
  logic [W-1:0] gx, gy, g;

  logic [W:0]   trial;
  logic [W-1:0] rem_sh;
  assign rem_sh = {rem[W-2:0], dvd[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};

  function automatic logic [31:0] sx(input logic [W-1:0] v);
    return 32'(signed'(v));
  endfunction

  always_comb begin
    n_form    = '0;
    d_form    = '0;
    make_form = 1'b1;
    gt_form   = 1'b0;
    lt_form   = 1'b0;
    eq_form   = 1'b0;
    err_form  = 1'b0;
    diff_gt   = p_adbn - p_anbd;
    diff_lt   = p_anbd - p_adbn;
    case (op)
      OP_NORM: begin n_form = an; d_form = ad; end
      OP_ADD:  begin n_form = p_anbd + p_adbn; d_form = p_adbd; end
      OP_SUB:  begin n_form = p_anbd - p_adbn; d_form = p_adbd; end
      OP_MUL:  begin n_form = p_anbn; d_form = p_adbd; end
      OP_DIV:  begin n_form = p_anbd; d_form = p_adbn; end
      OP_CMP: begin
        make_form = 1'b0;
        gt_form   = diff_gt[W-1];
        lt_form   = diff_lt[W-1];
        eq_form   = (an == bn) && (ad == bd);
        err_form  = (p_adbd == '0);
      end
      default: make_form = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_item.opcode;
      an <= in_item.a_num[W-1:0];
      ad <= in_item.a_den[W-1:0];
      bn <= in_item.b_num[W-1:0];
      bd <= in_item.b_den[W-1:0];
    end
    if (cmd.prod) begin
      p_anbd <= W'(an * bd);
      p_adbn <= W'(ad * bn);
      p_anbn <= W'(an * bn);
      p_adbd <= W'(ad * bd);
    end
    if (cmd.form) begin
      make <= make_form;
      gt   <= gt_form;
      lt   <= lt_form;
      eq   <= eq_form;
      err  <= err_form;
      n    <= n_form;
      d    <= d_form;
    end else if (cmd.gcd_init && make) begin
      // zero denominator forced to one, zero numerator gives 0/1
      if (d == '0) err <= 1'b1;
      if ((d == '0) || (n == '0)) d <= W'(1);
    end
    if (cmd.gcd_init) begin
      gx <= n; gy <= (d == '0) ? W'(1) : d;
      phase <= 2'd0;
    end
    if (cmd.div_init) begin
      cnt <= CW'(W);
      rem <= '0;
      case (phase)
        2'd0: begin dvd <= gx; dvs <= gy; end
        2'd1: begin dvd <= n;  dvs <= g;  end
        default: begin dvd <= d; dvs <= g; end
      endcase
    end else if (cmd.div_step) begin
      dvd <= {dvd[W-2:0], 1'b0};
      cnt <= cnt - CW'(1);
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    if (cmd.div_next) begin
      case (phase)
        2'd0: begin
          gx <= gy; gy <= rem;
          if (rem == '0) begin
            g <= gy;
            phase <= 2'd1;
          end
        end
        2'd1: begin n <= quo; phase <= 2'd2; end
        default: begin d <= quo; phase <= 2'd3; end
      endcase
    end
    if (cmd.emit) begin
      out_item.res_num <= make ? sx(n) : '0;
      out_item.res_den <= make ? sx(d) : '0;
      out_item.den_zero_error <= err;
      out_item.a_greater <= gt;
      out_item.a_less <= lt;
      out_item.a_equal <= eq;
    end
  end

  assign sts.need_gcd  = make && !n[W-1] && !d[W-1] && (n != '0) && (d != '0);
  assign sts.div_done  = (cnt == CW'(1));
  assign sts.gcd_done  = (phase == 2'd1);
  assign sts.quot_done = (phase == 2'd3);

endmodule

@@ hdl/rau_ctrl.sv @@
// controller state machine sequencing products, gcd and reduction
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rau_sts_t sts,
  output rau_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PROD = 7'b0000010,
    S_FORM = 7'b0000100,
    S_FIX  = 7'b0001000,
    S_DINI = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   step_last;  // last divide step happened in the previous cycle

  // accept new work in idle when the output slot is free or being drained
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin cmd.prod = 1'b1; state_next = S_FORM; end
      S_FORM: begin cmd.form = 1'b1; state_next = S_FIX; end
      S_FIX: begin
        cmd.gcd_init = 1'b1;
        state_next = sts.need_gcd ? S_DINI : S_EMIT;
      end
      S_DINI: begin
        // close out the division just finished before picking the next one
        if (step_last) cmd.div_next = 1'b1;
        else if (sts.quot_done) state_next = S_EMIT;
        else begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_DINI;
      end
      S_EMIT: if (!out_valid || out_ready) begin
        cmd.emit = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step_last <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      step_last <= (state == S_DIV) && sts.div_done;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == S_IDLE && out_valid)
    else $error("emit did not raise out_valid");
  a_load_prod: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_PROD)
    else $error("load not followed by products");

endmodule
